>>> sv/lfg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear fade gain package
// Shared widths, register indexes, item types and the classification codes
// passed from the front end to the back end.
// ----------------------------------------------------------------------------
package lfg_pkg;

  localparam int unsigned FRAME_BITS     = 40;
  localparam int unsigned SAMPLE_BITS    = 24;
  localparam int unsigned GAIN_BITS      = 16;
  localparam int unsigned Q_BITS         = 16;          // fade position fraction
  localparam int unsigned T_BITS         = Q_BITS + 1;  // position incl. 1.0
  localparam int unsigned CFG_INDEX_BITS = 8;
  localparam int unsigned CFG_DATA_BITS  = FRAME_BITS;

  // Cycles from the accepting edge to the edge that takes the result.
  localparam int unsigned LFG_LATENCY    = Q_BITS + 6;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_START = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_END   = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_START = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_END   = CFG_INDEX_BITS'(3);

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,   // before the fade: t = 0
    CLS_ONE  = 2'd1,   // after the fade: t = 1.0
    CLS_DIV  = 2'd2    // inside the fade: t from the divider
  } lfg_cls_e;

  typedef struct packed {
    logic [FRAME_BITS-1:0]         frame_index;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } lfg_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;
  } lfg_out_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0]  gain_start;
    logic [GAIN_BITS-1:0]  gain_end;
    logic [FRAME_BITS-1:0] fade_start_frame;
    logic [FRAME_BITS-1:0] fade_end_frame;
  } lfg_cfg_t;

  typedef struct packed {
    lfg_cls_e                      cls;
    logic [FRAME_BITS-1:0]         rem;
    logic [FRAME_BITS-1:0]         span;
    logic signed [SAMPLE_BITS-1:0] sample;
  } lfg_job_t;

endpackage

>>> sv/lfg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear fade gain front end
// Accepts items, classifies the frame against the fade window and registers
// the divider operands for the back end.
// ----------------------------------------------------------------------------
module lfg_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  lfg_pkg::lfg_in_t item_i,
  input  lfg_pkg::lfg_cfg_t cfg_i,
  output logic             busy_o,
  output logic             job_valid_o,
  output lfg_pkg::lfg_job_t job_o,
  input  logic             job_ready_i
);
  import lfg_pkg::*;

  logic     job_valid_q;
  lfg_job_t job_q, job_d;
  logic     accept;

  assign busy_o = job_valid_q & ~job_ready_i;
  assign accept = start_i & ~busy_o;

  always_comb begin
    job_d.rem    = item_i.frame_index - cfg_i.fade_start_frame;
    job_d.span   = cfg_i.fade_end_frame - cfg_i.fade_start_frame;
    job_d.sample = item_i.sample_in;
    if (cfg_i.fade_end_frame <= cfg_i.fade_start_frame) begin
      // Empty window: step to the end gain at the start frame.
      job_d.cls = (item_i.frame_index >= cfg_i.fade_start_frame) ? CLS_ONE : CLS_ZERO;
    end else if (item_i.frame_index <= cfg_i.fade_start_frame) begin
      job_d.cls = CLS_ZERO;
    end else if (item_i.frame_index >= cfg_i.fade_end_frame) begin
      job_d.cls = CLS_ONE;
    end else begin
      job_d.cls = CLS_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (accept) begin
      job_valid_q <= 1'b1;
    end else if (job_ready_i) begin
      job_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

>>> sv/lfg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear fade gain job queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lfg_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  lfg_pkg::lfg_job_t push_job_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output lfg_pkg::lfg_job_t pop_job_o
);
  import lfg_pkg::*;

  localparam int unsigned DEPTH     = 2;
  localparam int unsigned PTR_BITS  = $clog2(DEPTH);
  localparam int unsigned CNT_BITS  = $clog2(DEPTH + 1);

  lfg_job_t              mem [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic                  push, pop;

  assign push_ready_o = (count_q != CNT_BITS'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  // The back end never stalls: drain one entry every cycle.
  assign pop          = pop_valid_o;
  assign pop_job_o    = mem[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + CNT_BITS'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

>>> sv/lfg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear fade gain back end
// Pipelined restoring divider for the fade position, gain mix, sample
// scaling with rounding and saturation.
// ----------------------------------------------------------------------------
module lfg_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  lfg_pkg::lfg_job_t job_i,
  input  lfg_pkg::lfg_cfg_t cfg_i,
  output logic              done_o,
  output lfg_pkg::lfg_out_t result_o
);
  import lfg_pkg::*;

  localparam int unsigned PROD_BITS = GAIN_BITS + T_BITS;
  localparam int unsigned SUM_BITS  = PROD_BITS + 1;
  localparam int unsigned P_BITS    = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int unsigned PR_BITS   = P_BITS + 1;
  localparam int unsigned Y_BITS    = PR_BITS - 12;
  localparam logic [T_BITS-1:0]  T_ONE   = {1'b1, {Q_BITS{1'b0}}};
  localparam logic [SUM_BITS-1:0] G_HALF = SUM_BITS'(1) << (Q_BITS - 1);
  localparam logic signed [PR_BITS-1:0] P_HALF = PR_BITS'(2048);
  localparam logic signed [Y_BITS-1:0] Y_MAX =
    {{(Y_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [Y_BITS-1:0] Y_MIN =
    {{(Y_BITS - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  // Divider pipeline, one quotient bit per stage.
  logic                          div_vld_q  [Q_BITS];
  lfg_cls_e                      div_cls_q  [Q_BITS];
  logic [FRAME_BITS-1:0]         div_rem_q  [Q_BITS];
  logic [FRAME_BITS-1:0]         div_span_q [Q_BITS];
  logic [Q_BITS-1:0]             div_quo_q  [Q_BITS];
  logic signed [SAMPLE_BITS-1:0] div_smp_q  [Q_BITS];

  for (genvar k = 0; k < Q_BITS; k++) begin : g_div
    logic                          in_vld;
    lfg_cls_e                      in_cls;
    logic [FRAME_BITS-1:0]         in_rem, in_span;
    logic [Q_BITS-1:0]             in_quo;
    logic signed [SAMPLE_BITS-1:0] in_smp;
    logic [FRAME_BITS:0]           shifted, diff;
    logic                          take;

    if (k == 0) begin : g_first
      assign in_vld  = job_valid_i;
      assign in_cls  = job_i.cls;
      assign in_rem  = job_i.rem;
      assign in_span = job_i.span;
      assign in_quo  = '0;
      assign in_smp  = job_i.sample;
    end else begin : g_next
      assign in_vld  = div_vld_q[k-1];
      assign in_cls  = div_cls_q[k-1];
      assign in_rem  = div_rem_q[k-1];
      assign in_span = div_span_q[k-1];
      assign in_quo  = div_quo_q[k-1];
      assign in_smp  = div_smp_q[k-1];
    end

    assign shifted = {in_rem, 1'b0};
    assign diff    = shifted - {1'b0, in_span};
    assign take    = (shifted >= {1'b0, in_span});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[k] <= 1'b0;
      end else begin
        div_vld_q[k] <= in_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      div_cls_q[k]  <= in_cls;
      div_span_q[k] <= in_span;
      div_rem_q[k]  <= take ? diff[FRAME_BITS-1:0] : shifted[FRAME_BITS-1:0];
      div_quo_q[k]  <= {in_quo[Q_BITS-2:0], take};
      div_smp_q[k]  <= in_smp;
    end
  end

  // Fade position from the class and the quotient.
  logic [T_BITS-1:0] t_pos;
  always_comb begin
    case (div_cls_q[Q_BITS-1])
      CLS_ZERO: t_pos = '0;
      CLS_ONE:  t_pos = T_ONE;
      CLS_DIV:  t_pos = {1'b0, div_quo_q[Q_BITS-1]};
      default:  t_pos = '0;
    endcase
  end

  // Gain mix: two products, then the rounded sum.
  logic                          mix_vld_q, gain_vld_q, prod_vld_q, done_q;
  logic [PROD_BITS-1:0]          prod_s_q, prod_e_q;
  logic signed [SAMPLE_BITS-1:0] mix_smp_q, gain_smp_q;
  logic [SUM_BITS-1:0]           gain_sum;
  logic [GAIN_BITS-1:0]          gain_q;
  logic signed [P_BITS-1:0]      prod_q, prod_d;
  logic signed [PR_BITS-1:0]     prod_rnd;
  logic signed [Y_BITS-1:0]      y_val;
  lfg_out_t                      result_q, result_d;

  assign gain_sum = SUM_BITS'(prod_s_q) + SUM_BITS'(prod_e_q) + G_HALF;
  assign prod_d   = gain_smp_q * $signed({1'b0, gain_q});
  assign prod_rnd = $signed({prod_q[P_BITS-1], prod_q}) + P_HALF;
  assign y_val    = Y_BITS'(prod_rnd >>> 12);

  always_comb begin
    if (y_val > Y_MAX) begin
      result_d.sample_out = Y_MAX[SAMPLE_BITS-1:0];
      result_d.clipped    = 1'b1;
    end else if (y_val < Y_MIN) begin
      result_d.sample_out = Y_MIN[SAMPLE_BITS-1:0];
      result_d.clipped    = 1'b1;
    end else begin
      result_d.sample_out = y_val[SAMPLE_BITS-1:0];
      result_d.clipped    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_vld_q  <= 1'b0;
      gain_vld_q <= 1'b0;
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      mix_vld_q  <= div_vld_q[Q_BITS-1];
      gain_vld_q <= mix_vld_q;
      prod_vld_q <= gain_vld_q;
      done_q     <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_s_q   <= PROD_BITS'(cfg_i.gain_start) * PROD_BITS'(T_ONE - t_pos);
    prod_e_q   <= PROD_BITS'(cfg_i.gain_end) * PROD_BITS'(t_pos);
    mix_smp_q  <= div_smp_q[Q_BITS-1];
    gain_q     <= gain_sum[Q_BITS+GAIN_BITS-1:Q_BITS];
    gain_smp_q <= mix_smp_q;
    prod_q     <= prod_d;
    result_q   <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

>>> sv/linear_fade_gain_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear fade gain unit
// Scales a stream of audio samples by a gain that ramps linearly from
// gain_start to gain_end across a window of frame numbers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive start_i with one item (frame_index, sample_in); the
//   item is taken at an edge where start_i is high and busy_o is low. The
//   block takes one item every cycle; busy_o only rises if the job queue
//   fills, which the always-draining back end does not let happen.
//   Result channel: done_o marks result_o for exactly one cycle. The
//   receiver cannot stall; results leave in input order, one per item.
//   From the accepting edge to the edge that takes the result, an item passes
//   one front end register, one queue slot, sixteen divider stages
//   (one quotient bit each), two gain mix stages, one multiply stage and the
//   output register. Throughput is one item per cycle, set by the fully
//   pipelined divider.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 gain_start, 1 gain_end, 2 fade_start_frame, 3 fade_end_frame;
//   other indexes are dropped. Write only while no item is in flight.
//   Reset clears the configuration registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module linear_fade_gain_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  lfg_pkg::lfg_in_t                     item_i,
  output logic                                 busy_o,
  output logic                                 done_o,
  output lfg_pkg::lfg_out_t                    result_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lfg_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [lfg_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);
  import lfg_pkg::*;

  lfg_cfg_t cfg_q;
  logic     job_valid, job_ready, q_valid;
  lfg_job_t job, q_job;

  // Each write lands in the register file at its handshake edge; always ready.
  assign cfg_ready_o = 1'b1;

  // Register file: mask each write to the register's width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GAIN_START: cfg_q.gain_start       <= cfg_data_i[GAIN_BITS-1:0];
        REG_GAIN_END:   cfg_q.gain_end         <= cfg_data_i[GAIN_BITS-1:0];
        REG_FADE_START: cfg_q.fade_start_frame <= cfg_data_i[FRAME_BITS-1:0];
        REG_FADE_END:   cfg_q.fade_end_frame   <= cfg_data_i[FRAME_BITS-1:0];
        default: ;  // drop writes outside the register list
      endcase
    end
  end

  // Classify and register divider operands.
  lfg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .cfg_i       (cfg_q),
    .busy_o      (busy_o),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  // Decouple front and back.
  lfg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_job_i   (job),
    .push_ready_o (job_ready),
    .pop_valid_o  (q_valid),
    .pop_job_o    (q_job)
  );

  // Divide, mix the gain, scale and saturate.
  lfg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .cfg_i       (cfg_q),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

>>> sv/lfg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear fade gain checker
// Port-level checks on latency, backpressure and saturation of the fade unit.
// ----------------------------------------------------------------------------
module lfg_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input lfg_pkg::lfg_out_t result_o
);
  import lfg_pkg::*;

  logic accepted;
  assign accepted = start_i && !busy_o;

  // Every accepted item yields a result a fixed time later.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepted |-> ##LFG_LATENCY done_o)
    else $error("lfg: accepted item produced no result");

  // No result appears without an item behind it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accepted, LFG_LATENCY))
    else $error("lfg: result without a matching item");

  // A clipped result sits at one of the rails.
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.clipped) |->
      (result_o.sample_out == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
       result_o.sample_out == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
    else $error("lfg: clipped result off the rails");

  // Backpressure only ever follows an accepted item.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(accepted))
    else $error("lfg: busy without a pending item");

endmodule

bind linear_fade_gain_unit lfg_checker u_lfg_checker (.*);

>>> bench/tb_linear_fade_gain_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear fade gain unit testbench
// Streams audio items through the unit and checks every result against its
// own prediction of the gain ramp, rounding and saturation. The unit is
// reconfigured between streams while it is idle. Directed streams cover the
// window edges, zero span, a reversed window and rounding ties. Random
// streams cover many window shapes and gains.
// ----------------------------------------------------------------------------
module tb_linear_fade_gain_unit;
  import lfg_pkg::*;

  localparam int unsigned CLK_HALF    = 5;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned RAND_PHASES  = 12;
  localparam int unsigned PHASE_ITEMS  = 50;

  localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) << (SAMPLE_BITS - 1));
  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 16'h1000;  // 1.0 in Q4.12
  localparam logic [GAIN_BITS-1:0] GAIN_TOP   = 16'hFFFF;

  // Register indexes the unit must drop.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_LOW = CFG_INDEX_BITS'(4);
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_TOP = '1;

  // --------------------------------------------------------------------------
  // Clock, reset and unit inputs; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      start_i     = 1'b0;
  lfg_in_t                   item_i      = '0;
  logic                      cfg_valid_i = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i  = '0;
  logic                      busy_o;
  logic                      done_o;
  lfg_out_t                  result_o;
  logic                      cfg_ready_o;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  linear_fade_gain_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Shadow copy of the fade settings, updated at each register write.
  // --------------------------------------------------------------------------
  logic [GAIN_BITS-1:0]  cur_gain_start = '0;
  logic [GAIN_BITS-1:0]  cur_gain_end   = '0;
  logic [FRAME_BITS-1:0] cur_fade_start = '0;
  logic [FRAME_BITS-1:0] cur_fade_end   = '0;

  lfg_in_t  samples_to_send[$];   // items waiting for the driver
  lfg_out_t faded_due[$];         // predicted results, oldest first
  int unsigned mismatches  = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  // Predict one result: fade position from the frame, gain mix with round
  // half up, Q4.12 scaling with round half toward +inf, then saturation.
  function automatic lfg_out_t faded_sample(input logic [FRAME_BITS-1:0] frame,
                                            input logic signed [SAMPLE_BITS-1:0] smp);
    logic [63:0] pos;
    logic [63:0] span;
    logic [63:0] mix;
    longint      smp_l;
    longint      scaled;
    lfg_out_t    res;
    if (cur_fade_end <= cur_fade_start) begin
      // zero span or reversed window: step to gain_end at the start frame
      pos = (frame >= cur_fade_start) ? 64'd65536 : 64'd0;
    end else if (frame <= cur_fade_start) begin
      pos = 64'd0;
    end else if (frame >= cur_fade_end) begin
      pos = 64'd65536;
    end else begin
      span = 64'(cur_fade_end) - 64'(cur_fade_start);
      pos  = ((64'(frame) - 64'(cur_fade_start)) << Q_BITS) / span;
    end
    mix = 64'(cur_gain_start) * (64'd65536 - pos) + 64'(cur_gain_end) * pos + 64'd32768;
    smp_l  = smp;
    scaled = (smp_l * longint'(mix >> 16) + 2048) >>> 12;
    res.clipped = 1'b0;
    if (scaled > SAMPLE_MAX) begin
      scaled      = SAMPLE_MAX;
      res.clipped = 1'b1;
    end else if (scaled < SAMPLE_MIN) begin
      scaled      = SAMPLE_MIN;
      res.clipped = 1'b1;
    end
    res.sample_out = SAMPLE_BITS'(scaled);
    return res;
  endfunction

  function automatic logic [FRAME_BITS-1:0] rand_frame();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[FRAME_BITS-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present queued items in bursts with random gaps. An item is taken
  // at an edge with start_i high and busy_o low; predict its result there.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      item_i  <= '0;
    end else begin
      if (start_i && !busy_o) begin
        faded_due.push_back(faded_sample(item_i.frame_index, item_i.sample_in));
        void'(samples_to_send.pop_front());
      end
      if (start_i && busy_o) begin
        // hold the stalled item as it is
      end else if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (samples_to_send.size() != 0) begin
        start_i <= 1'b1;
        item_i  <= samples_to_send[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // open a new burst; a third of them run with no gap at all
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every done_o pulse must match the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lfg_out_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (faded_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d arrived with no item outstanding: sample %0d clip %0b",
                   results_seen, result_o.sample_out, result_o.clipped);
      end else begin
        want = faded_due.pop_front();
        if (result_o.sample_out !== want.sample_out || result_o.clipped !== want.clipped) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: expected sample %0d clip %0b, got sample %0d clip %0b",
                     results_seen, want.sample_out, want.clipped,
                     result_o.sample_out, result_o.clipped);
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("linear_fade_gain_unit verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Write one register and track it in the shadow copy at the handshake edge.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_GAIN_START: cur_gain_start = data[GAIN_BITS-1:0];
      REG_GAIN_END:   cur_gain_end   = data[GAIN_BITS-1:0];
      REG_FADE_START: cur_fade_start = data[FRAME_BITS-1:0];
      REG_FADE_END:   cur_fade_end   = data[FRAME_BITS-1:0];
      default: ;  // dropped by the unit
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // Write all four settings; gains carry random junk above bit 15.
  task automatic set_fade(input logic [GAIN_BITS-1:0] gs, input logic [GAIN_BITS-1:0] ge,
                          input logic [FRAME_BITS-1:0] fs, input logic [FRAME_BITS-1:0] fe);
    write_reg(REG_GAIN_START, {24'($urandom()), gs});
    write_reg(REG_GAIN_END, {24'($urandom()), ge});
    write_reg(REG_FADE_START, fs);
    write_reg(REG_FADE_END, fe);
  endtask

  task automatic queue_item(input logic [FRAME_BITS-1:0] frame,
                            input logic signed [SAMPLE_BITS-1:0] smp);
    lfg_in_t it;
    it.frame_index = frame;
    it.sample_in   = smp;
    samples_to_send.push_back(it);
  endtask

  // Wait until every queued item has been taken and every result has come.
  task automatic drain();
    while (samples_to_send.size() != 0 || faded_due.size() != 0 || start_i)
      @(posedge clk_i);
  endtask

  function automatic logic [GAIN_BITS-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return GAIN_TOP;
      2:       return GAIN_UNITY;
      default: return GAIN_BITS'($urandom());
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_BITS'(SAMPLE_MAX);
      1:       return SAMPLE_BITS'(SAMPLE_MIN);
      2:       return SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);  // rounding region
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // One random stream: pick a window shape and gains, then mostly frames
  // inside or on the edges of the window, some anywhere.
  task automatic random_phase(input int unsigned n_items);
    logic [FRAME_BITS-1:0] fs;
    logic [FRAME_BITS-1:0] fe;
    logic [FRAME_BITS-1:0] lo;
    logic [FRAME_BITS-1:0] hi;
    logic [FRAME_BITS-1:0] frame;
    logic [63:0]           span;
    logic [63:0]           width;
    fs   = rand_frame();
    span = 64'd0;
    case ($urandom_range(0, 5))
      0: fe = fs;                                      // zero span
      1: begin                                         // reversed window
        fe = rand_frame();
        if (fe > fs) begin
          lo = fs;
          fs = fe;
          fe = lo;
        end
      end
      2: span = 64'($urandom_range(1, 16));
      3: span = 64'($urandom_range(17, 1 << 20));
      4: span = 64'(rand_frame());
      default: begin                                   // full frame range
        fs = '0;
        fe = FRAME_MAX;
      end
    endcase
    if (span != 0) begin
      if ($urandom_range(0, 3) == 0) fs = FRAME_BITS'($urandom_range(0, 1000));
      if (64'(fs) > 64'(FRAME_MAX) - span) fs = FRAME_BITS'(64'(FRAME_MAX) - span);
      fe = FRAME_BITS'(64'(fs) + span);
    end
    set_fade(pick_gain(), pick_gain(), fs, fe);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED_LOW + CFG_INDEX_BITS'($urandom_range(0, 251)),
                                             rand_frame());
    lo    = (fs < fe) ? fs : fe;
    hi    = (fs < fe) ? fe : fs;
    width = 64'(hi) - 64'(lo) + 64'd1;
    repeat (n_items) begin
      case ($urandom_range(0, 9))
        0: frame = rand_frame();
        1: begin
          case ($urandom_range(0, 5))
            0:       frame = fs;
            1:       frame = fe;
            2:       frame = fs - 1'b1;
            3:       frame = fs + 1'b1;
            4:       frame = fe - 1'b1;
            default: frame = fe + 1'b1;
          endcase
        end
        default: frame = FRAME_BITS'(64'(lo) + ({$urandom(), $urandom()} % width));
      endcase
      queue_item(frame, pick_sample());
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero span at frame 0, gain_end of zero applies.
    queue_item('0, SAMPLE_BITS'(SAMPLE_MAX));
    queue_item(FRAME_MAX, SAMPLE_BITS'(SAMPLE_MIN));
    drain();

    // Ramp from unity to the top gain over 1024 frames; junk above the gain
    // bits must be masked, writes to unused indexes dropped.
    write_reg(REG_GAIN_START, 40'hAB_CDEF_1000);
    write_reg(REG_GAIN_END, 40'(GAIN_TOP));
    write_reg(REG_FADE_START, 40'd100);
    write_reg(REG_FADE_END, 40'd1124);
    write_reg(REG_UNUSED_LOW, FRAME_MAX);
    write_reg(REG_UNUSED_TOP, rand_frame());
    queue_item(40'd0, SAMPLE_BITS'(SAMPLE_MAX));
    queue_item(40'd100, SAMPLE_BITS'(SAMPLE_MIN));
    queue_item(40'd101, 24'sd4096);
    queue_item(40'd612, SAMPLE_BITS'(SAMPLE_MAX));   // clips high
    queue_item(40'd612, SAMPLE_BITS'(SAMPLE_MIN));   // clips low
    queue_item(40'd1123, 24'sd1);
    queue_item(40'd1124, -24'sd1);
    queue_item(FRAME_MAX, 24'sd0);
    drain();

    // Smallest gain and zero span: rounding ties go toward +inf.
    set_fade(16'd1, 16'd1, 40'd500, 40'd500);
    queue_item(40'd499, 24'sd2048);
    queue_item(40'd500, -24'sd2048);
    queue_item(40'd501, -24'sd2049);
    queue_item(40'd499, 24'sd6143);
    drain();

    // Reversed window: step to gain_end at the start frame.
    set_fade(GAIN_UNITY, 16'h2000, 40'd1000, 40'd10);
    queue_item(40'd999, 24'sd12345);
    queue_item(40'd1000, 24'sd12345);
    queue_item(40'd10, -24'sd7);
    drain();

    // Widest window.
    set_fade('0, GAIN_TOP, '0, FRAME_MAX);
    queue_item(FRAME_MAX - 1'b1, 24'sd4096);
    queue_item(40'd1, -24'sd4096);
    queue_item(FRAME_MAX, 24'sd123);
    drain();

    repeat (RAND_PHASES) random_phase(PHASE_ITEMS);

    // Let the pipeline settle, then make sure nothing extra shows up.
    repeat (LFG_LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0 && faded_due.size() == 0) begin
      $display("linear_fade_gain_unit verification clean");
    end else begin
      $display("linear_fade_gain_unit verification failed");
    end
    $finish;
  end

endmodule
